/* hdl/klex_pkg.sv */
`default_nettype none
package klex_pkg;

	localparam int MAX_IDENT   = 64;
	localparam int MAX_DIGITS  = 31;
	localparam int OFFSET_BITS = 16;
	localparam int LEN_CAP     = 64;
	localparam int QDEPTH      = 4;
	localparam int QAW         = $clog2(QDEPTH);

	localparam logic [5:0] TK_END     = 6'd0;
	localparam logic [5:0] TK_PRINT   = 6'd1;
	localparam logic [5:0] TK_INT     = 6'd2;
	localparam logic [5:0] TK_IF      = 6'd3;
	localparam logic [5:0] TK_ELSE    = 6'd4;
	localparam logic [5:0] TK_WHILE   = 6'd5;
	localparam logic [5:0] TK_RETURN  = 6'd6;
	localparam logic [5:0] TK_IDENT   = 6'd7;
	localparam logic [5:0] TK_NUMBER  = 6'd8;
	localparam logic [5:0] TK_LPAREN  = 6'd9;
	localparam logic [5:0] TK_RPAREN  = 6'd10;
	localparam logic [5:0] TK_LBRACE  = 6'd11;
	localparam logic [5:0] TK_RBRACE  = 6'd12;
	localparam logic [5:0] TK_ADD_EQ  = 6'd13;
	localparam logic [5:0] TK_SUB_EQ  = 6'd14;
	localparam logic [5:0] TK_MUL_EQ  = 6'd15;
	localparam logic [5:0] TK_DIV_EQ  = 6'd16;
	localparam logic [5:0] TK_ADD     = 6'd17;
	localparam logic [5:0] TK_SUB     = 6'd18;
	localparam logic [5:0] TK_MUL     = 6'd19;
	localparam logic [5:0] TK_DIV     = 6'd20;
	localparam logic [5:0] TK_EQ_EQ   = 6'd21;
	localparam logic [5:0] TK_NOT_EQ  = 6'd22;
	localparam logic [5:0] TK_LESS_EQ = 6'd23;
	localparam logic [5:0] TK_GRTR_EQ = 6'd24;
	localparam logic [5:0] TK_LESS    = 6'd25;
	localparam logic [5:0] TK_GRTR    = 6'd26;
	localparam logic [5:0] TK_NOT     = 6'd27;
	localparam logic [5:0] TK_TILDE   = 6'd28;
	localparam logic [5:0] TK_ASSIGN  = 6'd29;
	localparam logic [5:0] TK_SEMI    = 6'd30;
	localparam logic [5:0] TK_INVALID = 6'd31;
	localparam logic [5:0] TK_TOO_LONG = 6'd32;

	// keyword spellings, first character in the low byte
	localparam logic [47:0] KW_PRINT  = 48'h0074_6E69_7270;
	localparam logic [47:0] KW_INT    = 48'h0000_0074_6E69;
	localparam logic [47:0] KW_IF     = 48'h0000_0000_6669;
	localparam logic [47:0] KW_ELSE   = 48'h0000_6573_6C65;
	localparam logic [47:0] KW_WHILE  = 48'h0065_6C69_6877;
	localparam logic [47:0] KW_RETURN = 48'h6E72_7574_6572;

	typedef enum logic [1:0] {
		MODE_IDLE,
		MODE_WORD,
		MODE_NUM,
		MODE_OP
	} mode_t;

	typedef struct packed {
		logic [5:0]  kind;
		logic [15:0] start;
		logic [6:0]  length;
	} token_t;

	typedef struct packed {
		logic   two;
		token_t tok0;
		token_t tok1;
	} bundle_t;

	function automatic logic is_alpha(input logic [7:0] c);
		return (c >= 8'h61 && c <= 8'h7A) || (c >= 8'h41 && c <= 8'h5A) || c == 8'h5F;
	endfunction

	function automatic logic is_digit(input logic [7:0] c);
		return c >= 8'h30 && c <= 8'h39;
	endfunction

	function automatic logic [5:0] word_kind(input logic [6:0] len, input logic [47:0] pfx,
			input logic ovf);
		logic [5:0] k;
		k = TK_IDENT;
		if (ovf)
			k = TK_TOO_LONG;
		else if (len == 7'd5 && pfx == KW_PRINT)
			k = TK_PRINT;
		else if (len == 7'd3 && pfx == KW_INT)
			k = TK_INT;
		else if (len == 7'd2 && pfx == KW_IF)
			k = TK_IF;
		else if (len == 7'd4 && pfx == KW_ELSE)
			k = TK_ELSE;
		else if (len == 7'd5 && pfx == KW_WHILE)
			k = TK_WHILE;
		else if (len == 7'd6 && pfx == KW_RETURN)
			k = TK_RETURN;
		return k;
	endfunction

	function automatic logic [5:0] op_kind(input logic [7:0] op, input logic with_eq);
		logic [5:0] k;
		case (op)
			8'h2B: k = with_eq ? TK_ADD_EQ : TK_ADD;
			8'h2D: k = with_eq ? TK_SUB_EQ : TK_SUB;
			8'h2A: k = with_eq ? TK_MUL_EQ : TK_MUL;
			8'h2F: k = with_eq ? TK_DIV_EQ : TK_DIV;
			8'h3D: k = with_eq ? TK_EQ_EQ : TK_ASSIGN;
			8'h21: k = with_eq ? TK_NOT_EQ : TK_NOT;
			8'h3C: k = with_eq ? TK_LESS_EQ : TK_LESS;
			default: k = with_eq ? TK_GRTR_EQ : TK_GRTR;
		endcase
		return k;
	endfunction

	// TK_END means no single-character token
	function automatic logic [5:0] single_kind(input logic [7:0] c);
		logic [5:0] k;
		case (c)
			8'h28: k = TK_LPAREN;
			8'h29: k = TK_RPAREN;
			8'h7B: k = TK_LBRACE;
			8'h7D: k = TK_RBRACE;
			8'h7E: k = TK_TILDE;
			8'h3B: k = TK_SEMI;
			default: k = TK_END;
		endcase
		return k;
	endfunction

	function automatic logic is_op_char(input logic [7:0] c);
		return c == 8'h2B || c == 8'h2D || c == 8'h2A || c == 8'h2F ||
			c == 8'h3D || c == 8'h21 || c == 8'h3C || c == 8'h3E;
	endfunction

endpackage
`default_nettype wire

/* hdl/klex_front.sv */
`default_nettype none
module klex_front
	import klex_pkg::*;
(
	input  wire logic    clk,
	input  wire logic    arst_n,
	input  wire logic    in_valid,
	input  wire logic    in_ready,
	input  wire logic [7:0] in_byte,
	output logic         push,
	output bundle_t      push_data
);

	mode_t                  mode_q, mode_d;
	logic [7:0]             pend_q, pend_d;
	logic [OFFSET_BITS-1:0] start_q, start_d;
	logic [6:0]             len_q, len_d;
	logic [OFFSET_BITS-1:0] off_q, off_d;
	logic [47:0]            pfx_q, pfx_d;
	logic                   ovf_q, ovf_d;

	logic accept;
	assign accept = in_valid && in_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q  <= MODE_IDLE;
			pend_q  <= '0;
			start_q <= '0;
			len_q   <= '0;
			off_q   <= '0;
			pfx_q   <= '0;
			ovf_q   <= 1'b0;
		end else if (accept) begin
			mode_q  <= mode_d;
			pend_q  <= pend_d;
			start_q <= start_d;
			len_q   <= len_d;
			off_q   <= off_d;
			pfx_q   <= pfx_d;
			ovf_q   <= ovf_d;
		end
	end

	always_comb begin
		logic [7:0]  c;
		logic        done;
		logic [1:0]  n;
		token_t      t0, t1, tn;
		logic        have_new;
		logic [6:0]  limit;
		logic [5:0]  sk;
		c        = in_byte;
		done     = 1'b0;
		n        = 2'd0;
		t0       = '0;
		t1       = '0;
		tn       = '0;
		have_new = 1'b0;
		limit    = (mode_q == MODE_WORD) ? 7'(MAX_IDENT) : 7'(MAX_DIGITS);
		sk       = single_kind(c);
		mode_d   = mode_q;
		pend_d   = pend_q;
		start_d  = start_q;
		len_d    = len_q;
		pfx_d    = pfx_q;
		ovf_d    = ovf_q;
		off_d    = off_q + 1'b1;

		case (mode_q)
			MODE_OP: begin
				t0.kind   = op_kind(pend_q, c == 8'h3D);
				t0.start  = 16'(start_q);
				t0.length = (c == 8'h3D) ? 7'd2 : 7'd1;
				n         = 2'd1;
				done      = (c == 8'h3D);
				mode_d    = MODE_IDLE;
				pend_d    = '0;
			end
			MODE_WORD, MODE_NUM: begin
				if (is_digit(c) || (mode_q == MODE_WORD && is_alpha(c))) begin
					if (len_q < 7'd6)
						pfx_d = pfx_q | (48'(c) << {len_q[2:0], 3'b000});
					if (len_q >= limit)
						ovf_d = 1'b1;
					if (len_q < 7'(LEN_CAP))
						len_d = len_q + 7'd1;
					done = 1'b1;
				end else begin
					t0.kind   = (mode_q == MODE_WORD) ? word_kind(len_q, pfx_q, ovf_q)
						: (ovf_q ? TK_TOO_LONG : TK_NUMBER);
					t0.start  = 16'(start_q);
					t0.length = len_q;
					n         = 2'd1;
					mode_d    = MODE_IDLE;
				end
			end
			default: ;
		endcase

		if (!done) begin
			tn.start  = 16'(off_q);
			tn.length = 7'd1;
			if (c == 8'h00) begin
				// end of text: flush and restart the position
				tn.kind   = TK_END;
				tn.length = 7'd0;
				have_new  = 1'b1;
				mode_d    = MODE_IDLE;
				pend_d    = '0;
				start_d   = '0;
				len_d     = '0;
				off_d     = '0;
				pfx_d     = '0;
				ovf_d     = 1'b0;
			end else if (c == 8'h20 || c == 8'h09 || c == 8'h0A) begin
				have_new = 1'b0;
			end else if (is_alpha(c) || is_digit(c)) begin
				mode_d  = is_alpha(c) ? MODE_WORD : MODE_NUM;
				start_d = off_q;
				len_d   = 7'd1;
				pfx_d   = 48'(c);
				ovf_d   = 1'b0;
			end else if (sk != TK_END) begin
				tn.kind  = sk;
				have_new = 1'b1;
			end else if (is_op_char(c)) begin
				mode_d  = MODE_OP;
				pend_d  = c;
				start_d = off_q;
			end else begin
				tn.kind  = TK_INVALID;
				have_new = 1'b1;
			end
			if (have_new) begin
				if (n == 2'd0)
					t0 = tn;
				else
					t1 = tn;
				n = n + 2'd1;
			end
		end

		push           = accept && (n != 2'd0);
		push_data.two  = (n == 2'd2);
		push_data.tok0 = t0;
		push_data.tok1 = t1;
	end

endmodule
`default_nettype wire

/* hdl/klex_queue.sv */
`default_nettype none
module klex_queue
	import klex_pkg::*;
(
	input  wire logic    clk,
	input  wire logic    arst_n,
	input  wire logic    push,
	input  wire bundle_t push_data,
	output logic         not_full,
	input  wire logic    pop,
	output logic         not_empty,
	output bundle_t      pop_data
);

	bundle_t        slot_q [QDEPTH];
	logic [QAW-1:0] wr_q, rd_q;
	logic [QAW:0]   cnt_q;

	assign not_full  = cnt_q != (QAW+1)'(QDEPTH);
	assign not_empty = cnt_q != '0;
	assign pop_data  = slot_q[rd_q];

	always_ff @(posedge clk) begin
		if (push)
			slot_q[wr_q] <= push_data;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (push)
				wr_q <= wr_q + 1'b1;
			if (pop)
				rd_q <= rd_q + 1'b1;
			if (push && !pop)
				cnt_q <= cnt_q + 1'b1;
			else if (pop && !push)
				cnt_q <= cnt_q - 1'b1;
		end
	end

endmodule
`default_nettype wire

/* hdl/klex_back.sv */
`default_nettype none
module klex_back
	import klex_pkg::*;
(
	input  wire logic    clk,
	input  wire logic    arst_n,
	input  wire logic    q_not_empty,
	input  wire bundle_t q_data,
	output logic         q_pop,
	output logic         out_valid,
	input  wire logic    out_ready,
	output token_t       out_tok,
	output logic         out_last
);

	logic   valid_q;
	logic   second_q;
	token_t tok_q;
	token_t tok1_q;
	logic   last_q;
	logic   load;

	// output register is free when empty or its item leaves this cycle
	assign load  = !valid_q || out_ready;
	assign q_pop = load && !second_q && q_not_empty;

	assign out_valid = valid_q;
	assign out_tok   = tok_q;
	assign out_last  = last_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q  <= 1'b0;
			second_q <= 1'b0;
		end else if (load) begin
			if (second_q) begin
				valid_q  <= 1'b1;
				second_q <= 1'b0;
			end else begin
				valid_q  <= q_not_empty;
				second_q <= q_not_empty && q_data.two;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			if (second_q) begin
				tok_q  <= tok1_q;
				last_q <= 1'b1;
			end else begin
				tok_q  <= q_data.tok0;
				tok1_q <= q_data.tok1;
				last_q <= !q_data.two;
			end
		end
	end

endmodule
`default_nettype wire

/* hdl/keyword_operator_lexer_unit.sv */
`default_nettype none
// path: a token passes from the scanner through the token queue into the output register
// throughput: one byte per cycle while the token queue is not full; a byte that ends two
// tokens gives two output tokens in turn, absorbed by the four-entry token queue between scanner and output
// reset: arst_n clears the scanner state, text position, queue and output register
module keyword_operator_lexer_unit
	import klex_pkg::*;
(
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        s_tvalid,
	output logic             s_tready,
	input  wire logic [7:0]  s_tdata,   // text_byte
	output logic             m_tvalid,
	input  wire logic        m_tready,
	output logic [31:0]      m_tdata,   // token_kind, token_start, token_length
	output logic             m_tlast    // last_of_run
);

	logic    push, not_full, pop, not_empty;
	bundle_t push_data, pop_data;
	token_t  tok;

	assign s_tready = not_full;

	klex_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (s_tvalid),
		.in_ready  (not_full),
		.in_byte   (s_tdata),
		.push      (push),
		.push_data (push_data)
	);

	klex_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_data (push_data),
		.not_full  (not_full),
		.pop       (pop),
		.not_empty (not_empty),
		.pop_data  (pop_data)
	);

	klex_back u_back (
		.clk         (clk),
		.arst_n      (arst_n),
		.q_not_empty (not_empty),
		.q_data      (pop_data),
		.q_pop       (pop),
		.out_valid   (m_tvalid),
		.out_ready   (m_tready),
		.out_tok     (tok),
		.out_last    (m_tlast)
	);

	assign m_tdata = {3'b000, tok.length, tok.start, tok.kind};

endmodule
`default_nettype wire
